>>> src/bced_pkg.sv
// Shared types and constants for the button click event detector.
// No dependencies; every other file refers to it by scoped names.
package bced_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int TIME_W      = 32;
  localparam int WINDOW_W    = 16;
  localparam int PERIOD_W    = 8;
  localparam int PROD_W      = TIME_W + PERIOD_W;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LEVEL  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_PERIOD = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET     = 16'd250;
  localparam logic                IDLE_LEVEL_RESET = 1'b1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_CONFIRM = 3'b010,
    PH_HELD    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [WINDOW_W-1:0] window_ms;
    logic                idle_level;
    logic [PERIOD_W-1:0] period_ms;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] last_release_time;
    logic              click_pending;
    logic              last_was_double;
    logic [TIME_W-1:0] hold_ticks;
  } key_state_t;

  typedef struct packed {
    logic              click_event;
    logic              press_event;
    logic              release_event;
    logic              double_click_event;
    logic              hold_event;
    logic [TIME_W-1:0] duration_ms;
  } result_t;

endpackage

>>> src/bced_in_if.sv
// Scan channel: one sampled key level and a millisecond timestamp per word.
// Depends on bced_pkg for the time width.
interface bced_in_if;
  logic                        valid;
  logic                        ready;
  logic                        key_level;
  logic [bced_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output key_level, output now_ms, input ready);
  modport sink   (input valid, input key_level, input now_ms, output ready);
endinterface

>>> src/bced_out_if.sv
// Report channel: event flags and held duration, one word per scan tick.
// Depends on bced_pkg for the time width.
interface bced_out_if;
  logic                        valid;
  logic                        ready;
  logic                        click_event;
  logic                        press_event;
  logic                        release_event;
  logic                        double_click_event;
  logic                        hold_event;
  logic [bced_pkg::TIME_W-1:0] duration_ms;

  modport source (output valid, output click_event, output press_event,
                  output release_event, output double_click_event,
                  output hold_event, output duration_ms, input ready);
  modport sink   (input valid, input click_event, input press_event,
                  input release_event, input double_click_event,
                  input hold_event, input duration_ms, output ready);
endinterface

>>> src/bced_events.sv
// Per-tick event logic: next key state and the report word for one sample.
// Depends on bced_pkg for the state, config and result types.
module bced_events (
  input  bced_pkg::cfg_t                cfg,
  input  bced_pkg::key_state_t          state,
  input  logic                          key_level,
  input  logic [bced_pkg::TIME_W-1:0]   now_ms,
  output bced_pkg::key_state_t          state_next,
  output bced_pkg::result_t             result
);

  logic                          active;
  logic [bced_pkg::TIME_W-1:0]   since;
  logic [bced_pkg::TIME_W-1:0]   window_ext;
  logic [bced_pkg::TIME_W-1:0]   ticks_inc;
  logic [bced_pkg::TIME_W-1:0]   ticks_mul;
  logic [bced_pkg::PROD_W-1:0]   product;
  logic [bced_pkg::TIME_W-1:0]   held_ms;

  assign active     = (key_level != cfg.idle_level);
  assign since      = now_ms - state.last_release_time;
  assign window_ext = {{(bced_pkg::TIME_W - bced_pkg::WINDOW_W){1'b0}}, cfg.window_ms};
  // saturate the hold counter instead of wrapping
  assign ticks_inc  = (&state.hold_ticks) ? state.hold_ticks
                                          : state.hold_ticks + 1'b1;
  // hold ticks report the advanced count, release reports the count as is
  assign ticks_mul  = active ? ticks_inc : state.hold_ticks;
  assign product    = {{bced_pkg::PERIOD_W{1'b0}}, ticks_mul} *
                      {{bced_pkg::TIME_W{1'b0}}, cfg.period_ms};
  assign held_ms    = (|product[bced_pkg::PROD_W-1:bced_pkg::TIME_W])
                      ? {bced_pkg::TIME_W{1'b1}} : product[bced_pkg::TIME_W-1:0];

  always_comb begin
    state_next = state;
    result     = '0;
    unique case (state.phase)
      bced_pkg::PH_CONFIRM: begin
        if (active) begin
          result.press_event = 1'b1;
          state_next.phase   = bced_pkg::PH_HELD;
        end else begin
          state_next.phase   = bced_pkg::PH_IDLE;
        end
      end
      bced_pkg::PH_HELD: begin
        result.duration_ms = held_ms;
        if (active) begin
          state_next.hold_ticks = ticks_inc;
          result.hold_event     = 1'b1;
        end else begin
          state_next.phase             = bced_pkg::PH_IDLE;
          state_next.last_release_time = now_ms;
          state_next.hold_ticks        = '0;
          result.release_event         = 1'b1;
          if ((since < window_ext) && !state.last_was_double) begin
            result.double_click_event  = 1'b1;
            state_next.click_pending   = 1'b0;
            state_next.last_was_double = 1'b1;
          end else begin
            state_next.click_pending   = 1'b1;
            state_next.last_was_double = 1'b0;
          end
        end
      end
      default: begin
        // idle, and any stray phase code: check the pending click first
        if ((since > window_ext) && state.click_pending) begin
          result.click_event       = 1'b1;
          state_next.click_pending = 1'b0;
        end
        state_next.phase = active ? bced_pkg::PH_CONFIRM : bced_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

>>> src/button_click_event_detector_unit.sv
// Top level of the button click event detector: config registers, input
// and output registers, key state. Depends on bced_pkg, bced_in_if,
// bced_out_if and bced_events.
//
//   channel  | dir | word contents                              | handshake
//   ---------+-----+--------------------------------------------+-----------
//   scan     | in  | key_level, now_ms                          | valid/ready
//   report   | out | click, press, release, double click, hold, | valid/ready
//            |     | duration_ms                                |
//   cfg      | in  | cfg_index, cfg_data                        | cfg_we only
//
// Flow: one word per clock while report.ready holds; a sample held in the input
// register moves into the report register once that slot is free or being taken
// (the event logic and its 32x8 duration multiply sit between the two registers).
// Reset: synchronous on rst; clears valids, resets key state and loads the
// config defaults (window 250 ms, idle level 1, scan period 10 ms).
// Stalls: while report is held, the input register keeps one more sample,
// after which scan.ready drops until the report word is taken.
module button_click_event_detector_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bced_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bced_pkg::CFG_DATA_W-1:0]   cfg_data,
  bced_in_if.sink                           scan,
  bced_out_if.source                        report
);

  // configuration registers
  bced_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms  <= bced_pkg::WINDOW_RESET;
      cfg.idle_level <= bced_pkg::IDLE_LEVEL_RESET;
      cfg.period_ms  <= bced_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bced_pkg::REG_WINDOW:      cfg.window_ms  <= cfg_data;
        bced_pkg::REG_IDLE_LEVEL:  cfg.idle_level <= cfg_data[0];
        bced_pkg::REG_SCAN_PERIOD: cfg.period_ms  <= cfg_data[bced_pkg::PERIOD_W-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // input register
  logic                        s1_valid;
  logic                        s1_level;
  logic [bced_pkg::TIME_W-1:0] s1_now;
  logic                        s1_advance;

  // advance the input register whenever the report slot is free or being taken
  assign s1_advance = !report.valid || report.ready;
  assign scan.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_level <= scan.key_level;
      s1_now   <= scan.now_ms;
    end
  end

  // key state and event logic
  bced_pkg::key_state_t state;
  bced_pkg::key_state_t state_next;
  bced_pkg::result_t    result;

  bced_events u_events (
    .cfg        (cfg),
    .state      (state),
    .key_level  (s1_level),
    .now_ms     (s1_now),
    .state_next (state_next),
    .result     (result)
  );

  // commit the state only when the word moves into the report register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= bced_pkg::PH_IDLE;
      state.last_release_time <= '0;
      state.click_pending     <= 1'b0;
      state.last_was_double   <= 1'b1;
      state.hold_ticks        <= '0;
    end else if (s1_valid && s1_advance) begin
      state <= state_next;
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (s1_advance) begin
      report.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      report.click_event        <= result.click_event;
      report.press_event        <= result.press_event;
      report.release_event      <= result.release_event;
      report.double_click_event <= result.double_click_event;
      report.hold_event         <= result.hold_event;
      report.duration_ms        <= result.duration_ms;
    end
  end

  // checks
  a_ticks_zero_off_hold: assert property (@(posedge clk) disable iff (rst)
    (state.phase != bced_pkg::PH_HELD) |-> (state.hold_ticks == '0))
    else $error("hold counter nonzero outside held phase");

  a_pending_not_double: assert property (@(posedge clk) disable iff (rst)
    state.click_pending |-> !state.last_was_double)
    else $error("click pending while double-click eligibility is spent");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && report.valid && !report.ready) |-> !scan.ready)
    else $error("sample accepted with both registers full");

  a_press_alone: assert property (@(posedge clk) disable iff (rst)
    (report.valid && report.press_event) |->
      (!report.hold_event && !report.release_event && report.duration_ms == '0))
    else $error("press word carries hold, release or duration");

endmodule
